FILE: design/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg: shared types and constants for the cubic Bezier evaluator
// Coordinate and parameter types, register indexes and reset values.
// ----------------------------------------------------------------------------
package cbe_pkg;

  localparam int COORD_W = 16;
  localparam int U_W     = 17;
  localparam int IDX_W   = 4;

  // Unsigned Q1.16 one
  localparam logic [U_W-1:0] U_ONE = 17'h10000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [U_W-1:0]     param_t;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_P0_X = 4'd0,
    REG_P0_Y = 4'd1,
    REG_P1_X = 4'd2,
    REG_P1_Y = 4'd3,
    REG_P2_X = 4'd4,
    REG_P2_Y = 4'd5,
    REG_P3_X = 4'd6,
    REG_P3_Y = 4'd7
  } reg_idx_t;

  // Reset values of the control points
  localparam coord_t RST_P0_X = -16'sd1024;
  localparam coord_t RST_P0_Y =  16'sd768;
  localparam coord_t RST_P1_X = -16'sd640;
  localparam coord_t RST_P1_Y = -16'sd640;
  localparam coord_t RST_P2_X =  16'sd640;
  localparam coord_t RST_P2_Y = -16'sd256;
  localparam coord_t RST_P3_X =  16'sd768;
  localparam coord_t RST_P3_Y =  16'sd1024;

  // The four control points as held in configuration
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    coord_t x3;
    coord_t y3;
  } points_t;

endpackage

FILE: design/cbe_lerp_cell.sv
// ----------------------------------------------------------------------------
// cbe_lerp_cell: one registered linear interpolation cell
// q = floor(((1-u)*a + u*b)), computed as a + ((u*(b-a)) >>> 16).
// ----------------------------------------------------------------------------
module cbe_lerp_cell (
  input  logic           clk,
  input  logic           en,
  input  cbe_pkg::param_t u,
  input  cbe_pkg::coord_t a,
  input  cbe_pkg::coord_t b,
  output cbe_pkg::param_t u_out,
  output cbe_pkg::coord_t q
);
  import cbe_pkg::*;

  logic signed [COORD_W:0]       diff;
  logic signed [U_W+COORD_W+1:0] prod;
  logic signed [COORD_W+2:0]     sum;

  // a<<16 is a multiple of 65536, so the floor only acts on the product
  always_comb begin
    diff = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    diff = -diff;
    prod = $signed({1'b0, u}) * diff;
    sum  = {{3{a[COORD_W-1]}}, a} +
           {{2{prod[U_W+COORD_W-1]}}, prod[U_W+COORD_W-1:16]};
  end

  // Result and parameter hand on to the next round
  always_ff @(posedge clk) begin
    if (en) begin
      q     <= sum[COORD_W-1:0];
      u_out <= u;
    end
  end

endmodule

FILE: design/cbe_cfg_regs.sv
// ----------------------------------------------------------------------------
// cbe_cfg_regs: control point registers
// Eight 16-bit write-only registers; writes above the last index are dropped.
// ----------------------------------------------------------------------------
module cbe_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cbe_pkg::IDX_W-1:0]  cfg_index,
  input  cbe_pkg::coord_t            cfg_data,
  output cbe_pkg::points_t           pts
);
  import cbe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      pts.x0 <= RST_P0_X;
      pts.y0 <= RST_P0_Y;
      pts.x1 <= RST_P1_X;
      pts.y1 <= RST_P1_Y;
      pts.x2 <= RST_P2_X;
      pts.y2 <= RST_P2_Y;
      pts.x3 <= RST_P3_X;
      pts.y3 <= RST_P3_Y;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_P0_X: pts.x0 <= cfg_data;
        REG_P0_Y: pts.y0 <= cfg_data;
        REG_P1_X: pts.x1 <= cfg_data;
        REG_P1_Y: pts.y1 <= cfg_data;
        REG_P2_X: pts.x2 <= cfg_data;
        REG_P2_Y: pts.y2 <= cfg_data;
        REG_P3_X: pts.x3 <= cfg_data;
        REG_P3_Y: pts.y3 <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: design/cubic_bezier_point_eval.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval: de Casteljau point evaluator for one cubic segment
// Three rounds of interpolation cells turn a parameter into a curve point.
// ----------------------------------------------------------------------------
// Takes one parameter u per cycle and returns one point per cycle unless
// stalled. A point passes through three registered rounds of de Casteljau
// interpolation, each a row of cells with one 17x17 multiplier apiece (six,
// then four, then two). The rounds stall independently, so bubbles close up
// when the output is held. Values of u above 1.0 are clamped to 1.0 and give
// P3. Control points are to be written through the configuration port while
// no transfer is in flight; the block itself does not enforce this.
module cubic_bezier_point_eval (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [cbe_pkg::IDX_W-1:0]  cfg_index,
  input  cbe_pkg::coord_t            cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  cbe_pkg::param_t            u,
  output logic                       out_valid,
  input  logic                       out_stall,
  output cbe_pkg::coord_t            curve_x,
  output cbe_pkg::coord_t            curve_y
);
  import cbe_pkg::*;

  points_t pts;
  param_t  u_sat;
  param_t  u1;
  param_t  u2;
  coord_t  ax0, ax1, ax2, ay0, ay1, ay2;
  coord_t  bx0, bx1, by0, by1;
  logic    v1, v2, v3;
  logic    adv1, adv2, adv3;

  cbe_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pts       (pts)
  );

  // Per-round advance, each round moves when its slot frees up
  always_comb begin
    adv3     = !v3 || !out_stall;
    adv2     = !v2 || adv3;
    adv1     = !v1 || adv2;
    in_stall = !adv1;
    u_sat    = (u > U_ONE) ? U_ONE : u;
  end

  // Valid bits of the three rounds
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  assign out_valid = v3;

  // Round one
  cbe_lerp_cell c1x0 (.clk(clk), .en(adv1), .u(u_sat), .a(pts.x0), .b(pts.x1),
                      .u_out(u1), .q(ax0));
  cbe_lerp_cell c1x1 (.clk(clk), .en(adv1), .u(u_sat), .a(pts.x1), .b(pts.x2),
                      .u_out(), .q(ax1));
  cbe_lerp_cell c1x2 (.clk(clk), .en(adv1), .u(u_sat), .a(pts.x2), .b(pts.x3),
                      .u_out(), .q(ax2));
  cbe_lerp_cell c1y0 (.clk(clk), .en(adv1), .u(u_sat), .a(pts.y0), .b(pts.y1),
                      .u_out(), .q(ay0));
  cbe_lerp_cell c1y1 (.clk(clk), .en(adv1), .u(u_sat), .a(pts.y1), .b(pts.y2),
                      .u_out(), .q(ay1));
  cbe_lerp_cell c1y2 (.clk(clk), .en(adv1), .u(u_sat), .a(pts.y2), .b(pts.y3),
                      .u_out(), .q(ay2));

  // Round two
  cbe_lerp_cell c2x0 (.clk(clk), .en(adv2), .u(u1), .a(ax0), .b(ax1),
                      .u_out(u2), .q(bx0));
  cbe_lerp_cell c2x1 (.clk(clk), .en(adv2), .u(u1), .a(ax1), .b(ax2),
                      .u_out(), .q(bx1));
  cbe_lerp_cell c2y0 (.clk(clk), .en(adv2), .u(u1), .a(ay0), .b(ay1),
                      .u_out(), .q(by0));
  cbe_lerp_cell c2y1 (.clk(clk), .en(adv2), .u(u1), .a(ay1), .b(ay2),
                      .u_out(), .q(by1));

  // Round three, registered straight onto the output
  cbe_lerp_cell c3x (.clk(clk), .en(adv3), .u(u2), .a(bx0), .b(bx1),
                     .u_out(), .q(curve_x));
  cbe_lerp_cell c3y (.clk(clk), .en(adv3), .u(u2), .a(by0), .b(by1),
                     .u_out(), .q(curve_y));

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the cubic Bezier point evaluator
// Loads several sets of control points through the register port and streams
// curve parameters past a predictor. Every curve point that comes out is
// checked against the predicted one, in order. Both sides idle at random but in the last set.
// ----------------------------------------------------------------------------
module tb_top;
  import cbe_pkg::*;

  localparam int     N_POINT_REGS = REG_P3_Y + 1;
  localparam coord_t COORD_MIN    = -16'sd32768;
  localparam coord_t COORD_MAX    = 16'sd32767;
  localparam int     LONG_HOLD    = 120;
  localparam int     HOLD_AT      = 150;
  localparam int     MAX_REPORTS  = 40;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } curve_pt_t;

  // Predicts curve points and keeps those still to come out of the block
  class bezier_scoreboard;
    coord_t    ctrl[N_POINT_REGS];
    curve_pt_t pending_pts[$];
    int        n_errors;
    int        n_checked;

    function new();
      ctrl[REG_P0_X] = RST_P0_X;
      ctrl[REG_P0_Y] = RST_P0_Y;
      ctrl[REG_P1_X] = RST_P1_X;
      ctrl[REG_P1_Y] = RST_P1_Y;
      ctrl[REG_P2_X] = RST_P2_X;
      ctrl[REG_P2_Y] = RST_P2_Y;
      ctrl[REG_P3_X] = RST_P3_X;
      ctrl[REG_P3_Y] = RST_P3_Y;
      n_errors  = 0;
      n_checked = 0;
    endfunction

    // Indexes past the last point register are dropped by the block
    function void load_reg(logic [IDX_W-1:0] idx, coord_t val);
      if (idx <= REG_P3_Y) ctrl[idx[2:0]] = val;
    endfunction

    // One interpolation step: exact sum, then floor by arithmetic shift
    function longint lerp(longint a, longint b, longint t);
      longint acc;
      acc = (longint'(U_ONE) - t) * a + t * b;
      return acc >>> 16;
    endfunction

    function coord_t casteljau(coord_t c0, coord_t c1, coord_t c2, coord_t c3,
                               longint t);
      longint a0, a1, a2, b0, b1;
      a0 = lerp(c0, c1, t);
      a1 = lerp(c1, c2, t);
      a2 = lerp(c2, c3, t);
      b0 = lerp(a0, a1, t);
      b1 = lerp(a1, a2, t);
      return coord_t'(lerp(b0, b1, t));
    endfunction

    // Parameter accepted: work out its point, clamping u above one
    function void note_param(param_t p);
      longint    t;
      curve_pt_t pt;
      t = (p > U_ONE) ? longint'(U_ONE) : longint'(p);
      pt.x = casteljau(ctrl[REG_P0_X], ctrl[REG_P1_X], ctrl[REG_P2_X],
                       ctrl[REG_P3_X], t);
      pt.y = casteljau(ctrl[REG_P0_Y], ctrl[REG_P1_Y], ctrl[REG_P2_Y],
                       ctrl[REG_P3_Y], t);
      pending_pts.push_back(pt);
    endfunction

    function void flag_error();
      n_errors++;
    endfunction

    // Point transferred out: compare with the oldest prediction
    function void check_point(coord_t x, coord_t y);
      curve_pt_t exp_pt;
      if (pending_pts.size() == 0) begin
        flag_error();
        if (n_errors <= MAX_REPORTS)
          $display("%0t: unexpected point, expected none, got x=%0d y=%0d",
                   $time, x, y);
        return;
      end
      exp_pt = pending_pts.pop_front();
      n_checked++;
      if (x !== exp_pt.x) begin
        flag_error();
        if (n_errors <= MAX_REPORTS)
          $display("%0t: curve_x expected %0d, got %0d", $time, exp_pt.x, x);
      end
      if (y !== exp_pt.y) begin
        flag_error();
        if (n_errors <= MAX_REPORTS)
          $display("%0t: curve_y expected %0d, got %0d", $time, exp_pt.y, y);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  coord_t           cfg_data;
  logic             in_valid;
  logic             in_stall;
  param_t           u;
  logic             out_valid;
  logic             out_stall;
  coord_t           curve_x;
  coord_t           curve_y;

  bezier_scoreboard sb;
  bit               quiet;

  cubic_bezier_point_eval u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .u         (u),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .curve_x   (curve_x),
    .curve_y   (curve_y)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  // Register write, taken at the next rising edge
  task automatic write_reg(logic [IDX_W-1:0] idx, coord_t val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    sb.load_reg(idx, val);
  endtask

  // New control points, preceded by a write to an unused index
  task automatic load_points(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                             coord_t x2, coord_t y2, coord_t x3, coord_t y3);
    write_reg(IDX_W'(REG_P3_Y + 1 + $urandom_range(0, 7)), coord_t'($urandom));
    write_reg(REG_P0_X, x0);
    write_reg(REG_P0_Y, y0);
    write_reg(REG_P1_X, x1);
    write_reg(REG_P1_Y, y1);
    write_reg(REG_P2_X, x2);
    write_reg(REG_P2_Y, y2);
    write_reg(REG_P3_X, x3);
    write_reg(REG_P3_Y, y3);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one parameter and hold it until the transfer
  task automatic send_param(param_t p);
    @(negedge clk);
    in_valid = 1'b1;
    u        = p;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_param(p);
  endtask

  task automatic sender_gap(int n);
    @(negedge clk);
    in_valid = 1'b0;
    u        = param_t'($urandom_range(0, 17'h1FFFF));
    repeat (n) @(posedge clk);
  endtask

  // Idle the input, let every point out, then allow for the pipeline depth
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_pts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic param_t rand_param();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? U_ONE : param_t'(0);
      1:       return param_t'($urandom_range(U_ONE + 1, 17'h1FFFF));
      default: return param_t'($urandom_range(0, U_ONE));
    endcase
  endfunction

  // Coordinate for a random point set: 0 full range, 1 near origin, 2 extremes
  function automatic coord_t pick_coord(int mode);
    case (mode)
      0:       return coord_t'($urandom_range(0, 16'hFFFF));
      1:       return coord_t'(int'($urandom_range(0, 2048)) - 1024);
      default: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
    endcase
  endfunction

  task automatic run_directed();
    send_param(param_t'(0));
    send_param(param_t'(1));
    send_param(param_t'(17'h08000));
    send_param(param_t'(17'h0FFFF));
    send_param(U_ONE);
    send_param(param_t'(U_ONE + 1));
    send_param(param_t'(17'h1FFFF));
    send_param(param_t'(17'h15555));
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if (!quiet && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 15));
      send_param(rand_param());
    end
  endtask

  // Output side: random stalls, one long hold-off, checks on each transfer
  initial begin
    int stall_left;
    bit held_long;
    stall_left = 0;
    held_long  = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_point(curve_x, curve_y);
      @(negedge clk);
      if (!held_long && sb.n_checked >= HOLD_AT) begin
        held_long  = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
      end
    end
  end

  // Stimulus
  initial begin
    int mode;
    sb        = new();
    quiet     = 1'b0;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    u         = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset points, then the coordinate extremes
    run_directed();
    wait_drained();
    load_points(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    run_directed();
    wait_drained();
    load_points(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
    run_directed();
    wait_drained();

    // Random point sets; the last one runs without idling
    for (int ph = 0; ph < 6; ph++) begin
      mode = ph % 3;
      load_points(pick_coord(mode), pick_coord(mode), pick_coord(mode),
                  pick_coord(mode), pick_coord(mode), pick_coord(mode),
                  pick_coord(mode), pick_coord(mode));
      if (ph == 5) quiet = 1'b1;
      run_random(72);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (sb.n_errors == 0 && sb.pending_pts.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
